### hw/rtl/r2iq_pkg.sv
`timescale 1ns / 1ps

package r2iq_pkg;

	localparam int DEF_SAMPLE_WIDTH    = 16;
	localparam int DEF_PHASE_WIDTH     = 32;
	localparam int DEF_TABLE_ADDR_BITS = 10;
	localparam int DEF_COEF_WIDTH      = 16;

	// cosine/sine entries are signed Q1.30
	localparam int TRIG_FRAC = 30;
	localparam int TRIG_W    = 32;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		CFG_CONVERT_ENABLE     = 2'd0,
		CFG_PHASE_STEP         = 2'd1,
		CFG_START_PHASE        = 2'd2,
		CFG_FILTER_COEFFICIENT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LUT,
		ST_MIX_I,
		ST_MIX_Q,
		ST_FLT_I,
		ST_FLT_Q,
		ST_UPD,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MUL_X_COS,
		MUL_X_SIN,
		MUL_DI_COEF,
		MUL_DQ_COEF
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_trig;
		logic     ld_iraw;
		logic     ld_qraw;
		logic     ld_yi;
		logic     ld_yq;
		logic     ld_out;
	} ctrl_t;

endpackage

### hw/rtl/r2iq_mul.sv
`timescale 1ns / 1ps

module r2iq_mul #(
	parameter int AW = 33,
	parameter int BW = 32
) (
	input  logic                       clk,
	input  logic signed [AW-1:0]       a,
	input  logic signed [BW-1:0]       b,
	output logic signed [AW+BW-1:0]    p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### hw/rtl/r2iq_trig_rom.sv
`timescale 1ns / 1ps

module r2iq_trig_rom import r2iq_pkg::*; #(
	parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS
) (
	input  logic                              clk,
	input  logic                              ld,
	input  logic        [TABLE_ADDR_BITS-1:0] addr,
	output logic signed [TRIG_W-1:0]          cos_q,
	output logic signed [TRIG_W-1:0]          sin_q
);

	localparam int QS      = TABLE_ADDR_BITS - 2;
	localparam int QUARTER = 1 << QS;
	localparam logic [63:0] RND_Q30 = 64'd1 << (TRIG_FRAC - 1);
	localparam logic [63:0] ONE_Q30 = 64'd1 << TRIG_FRAC;

	// Q30 product, rounded half up
	function automatic logic [63:0] mulr(input logic [63:0] a, input logic [63:0] b);
		return (a * b + RND_Q30) >> TRIG_FRAC;
	endfunction

	function automatic logic [63:0] theta_of(input int k);
		logic [63:0] r;
		r = 64'(k);
		return (r * HALF_PI_Q30 + 64'(QUARTER / 2)) >> QS;
	endfunction

	function automatic logic [TRIG_FRAC:0] clamp_q30(input logic signed [64:0] sum);
		if (sum < 0)
			return '0;
		if (sum > $signed({1'b0, ONE_Q30}))
			return ONE_Q30[TRIG_FRAC:0];
		return sum[TRIG_FRAC:0];
	endfunction

	function automatic logic [TRIG_FRAC:0] series_cos(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [64:0] sum;
		x2  = mulr(x, x);
		t   = ONE_Q30;
		sum = $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd1) / 64'd2;     sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd6) / 64'd12;    sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd15) / 64'd30;   sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd28) / 64'd56;   sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd45) / 64'd90;   sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd66) / 64'd132;  sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd91) / 64'd182;  sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd120) / 64'd240; sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd153) / 64'd306; sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd190) / 64'd380; sum = sum + $signed({1'b0, t});
		return clamp_q30(sum);
	endfunction

	function automatic logic [TRIG_FRAC:0] series_sin(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [64:0] sum;
		x2  = mulr(x, x);
		t   = x;
		sum = $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd3) / 64'd6;     sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd10) / 64'd20;   sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd21) / 64'd42;   sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd36) / 64'd72;   sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd55) / 64'd110;  sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd78) / 64'd156;  sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd105) / 64'd210; sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd136) / 64'd272; sum = sum + $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd171) / 64'd342; sum = sum - $signed({1'b0, t});
		t = (mulr(t, x2) + 64'd210) / 64'd420; sum = sum + $signed({1'b0, t});
		return clamp_q30(sum);
	endfunction

	// first-quadrant tables, magnitude only
	logic [TRIG_FRAC:0] cos_tab [QUARTER];
	logic [TRIG_FRAC:0] sin_tab [QUARTER];

	for (genvar k = 0; k < QUARTER; k++) begin : g_tab
		localparam logic [TRIG_FRAC:0] CV = series_cos(theta_of(k));
		localparam logic [TRIG_FRAC:0] SV = series_sin(theta_of(k));
		assign cos_tab[k] = CV;
		assign sin_tab[k] = SV;
	end

	logic        [1:0]        quad;
	logic        [QS-1:0]     r;
	logic signed [TRIG_W-1:0] cq;
	logic signed [TRIG_W-1:0] sq;
	logic signed [TRIG_W-1:0] c_d;
	logic signed [TRIG_W-1:0] s_d;

	assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
	assign r    = addr[QS-1:0];
	assign cq   = $signed(TRIG_W'(cos_tab[r]));
	assign sq   = $signed(TRIG_W'(sin_tab[r]));

	// sine of k is cosine of k minus a quarter turn
	always_comb begin
		unique case (quad)
			2'd0: begin c_d = cq;  s_d = sq;  end
			2'd1: begin c_d = -sq; s_d = cq;  end
			2'd2: begin c_d = -cq; s_d = -sq; end
			2'd3: begin c_d = sq;  s_d = -cq; end
			default: begin c_d = cq; s_d = sq; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cos_q <= c_d;
			sin_q <= s_d;
		end
	end

endmodule

### hw/rtl/r2iq_seq.sv
`timescale 1ns / 1ps

module r2iq_seq import r2iq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  convert_en,
	input  logic  out_free,
	output logic  in_ready,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = convert_en ? ST_LUT : ST_FIN;
			end
			ST_LUT:   state_d = ST_MIX_I;
			ST_MIX_I: state_d = ST_MIX_Q;
			ST_MIX_Q: state_d = ST_FLT_I;
			ST_FLT_I: state_d = ST_FLT_Q;
			ST_FLT_Q: state_d = ST_UPD;
			ST_UPD:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// product register holds the product of the operands selected in the previous cycle
	always_comb begin
		in_ready     = 1'b0;
		ctrl         = '0;
		ctrl.mul_sel = MUL_X_COS;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_LUT:   ctrl.ld_trig = 1'b1;
			ST_MIX_I: ctrl.mul_sel = MUL_X_COS;
			ST_MIX_Q: begin
				ctrl.mul_sel = MUL_X_SIN;
				ctrl.ld_iraw = 1'b1;
			end
			ST_FLT_I: begin
				ctrl.mul_sel = MUL_DI_COEF;
				ctrl.ld_qraw = 1'b1;
			end
			ST_FLT_Q: begin
				ctrl.mul_sel = MUL_DQ_COEF;
				ctrl.ld_yi   = 1'b1;
			end
			ST_UPD:   ctrl.ld_yq = 1'b1;
			ST_FIN:   ctrl.ld_out = out_free;
			default:  in_ready = 1'b0;
		endcase
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after an accepted item");

endmodule

### hw/rtl/real_to_iq_downconverter_lpf.sv
`timescale 1ns / 1ps

// Real-to-IQ downconverter with one-pole low-pass smoothing. Each accepted
// sample advances the phase accumulator and, with convert_enable set, is mixed
// with a quarter-wave cosine/sine table to I = x*cos, Q = -x*sin, each then
// smoothed by y = (1-a)*raw + a*y and rounded/saturated to the sample width.
// With convert_enable clear the sample leaves as I and Q is zero. One signed
// multiplier serves both mixer products and both filter updates in turn, so
// an enabled item steps through accept, table read, four multiplier passes,
// update and output before the next accept; a bypassed item goes from accept
// to output. The output register frees the sequencer once it is loaded; it
// only waits when the previous result has not been taken. The user must write
// configuration only while no item is in flight; the block does not check it.

module real_to_iq_downconverter_lpf import r2iq_pkg::*; #(
	parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
	parameter int PHASE_WIDTH     = DEF_PHASE_WIDTH,
	parameter int TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
	parameter int COEF_WIDTH      = DEF_COEF_WIDTH,
	localparam int IN_TDW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_TDW-1:0]  s_axis_tdata,   // sample
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_TDW-1:0] m_axis_tdata,   // i_out, q_out
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int PW    = PHASE_WIDTH;
	localparam int CW    = COEF_WIDTH;
	localparam int GUARD = ((61 - SW - CW) < 15) ? (61 - SW - CW) : 15;
	localparam int STW   = SW + 1 + GUARD;
	localparam int MIX_SHIFT = TRIG_FRAC - GUARD;
	localparam int MA    = STW + 1;
	localparam int MB    = TRIG_W;
	localparam int PRW   = MA + MB;

	localparam logic [PRW:0] MIX_HALF = (PRW + 1)'(1) << (MIX_SHIFT - 1);
	localparam logic [PRW:0] FLT_HALF = (PRW + 1)'(1) << (CW - 1);
	localparam logic [STW:0] OUT_HALF = (STW + 1)'(1) << (GUARD - 1);
	localparam logic signed [STW-1:0] ST_MAX = {1'b0, {(STW - 1){1'b1}}};
	localparam logic signed [STW-1:0] ST_MIN = {1'b1, {(STW - 1){1'b0}}};
	localparam logic signed [SW-1:0]  SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0]  SMP_MIN = {1'b1, {(SW - 1){1'b0}}};

	// config registers
	logic        en_q;
	logic [31:0] step_q;
	logic [31:0] start_q;
	logic [15:0] coef_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			step_q  <= '0;
			start_q <= '0;
			coef_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_CONVERT_ENABLE:     en_q    <= cfg_data[0];
				CFG_PHASE_STEP:         step_q  <= cfg_data;
				CFG_START_PHASE:        start_q <= cfg_data;
				CFG_FILTER_COEFFICIENT: coef_q  <= cfg_data[15:0];
				default:                en_q    <= en_q;
			endcase
		end
	end

	// registers rescaled to internal formats
	logic [PW-1:0] step_ph;
	logic [PW-1:0] start_ph;
	logic [CW-1:0] coef;

	if (PW >= 32) begin : g_ph_wide
		assign step_ph  = PW'(step_q) << (PW - 32);
		assign start_ph = PW'(start_q) << (PW - 32);
	end else begin : g_ph_narrow
		assign step_ph  = step_q[31 -: PW];
		assign start_ph = start_q[31 -: PW];
	end

	if (CW >= 16) begin : g_coef_wide
		assign coef = CW'(coef_q) << (CW - 16);
	end else begin : g_coef_narrow
		assign coef = coef_q[15 -: CW];
	end

	// sequencer
	ctrl_t ctrl;
	logic  in_fire;
	logic  out_free;
	logic  out_valid_q;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	r2iq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.convert_en (en_q),
		.out_free   (out_free),
		.in_ready   (s_axis_tready),
		.ctrl       (ctrl)
	);

	// phase and input capture
	logic [PW-1:0]              acc_q;
	logic [PW-1:0]              acc_next;
	logic [PW-1:0]              phase;
	logic [TABLE_ADDR_BITS-1:0] addr_q;
	logic signed [SW-1:0]       x_q;
	logic                       byp_q;

	assign acc_next = acc_q + step_ph;
	assign phase    = start_ph + acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			byp_q <= 1'b0;
		end else if (in_fire) begin
			acc_q <= acc_next;
			byp_q <= !en_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= $signed(s_axis_tdata[SW-1:0]);
			addr_q <= phase[PW-1 -: TABLE_ADDR_BITS];
		end
	end

	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;

	r2iq_trig_rom #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom (
		.clk   (clk),
		.ld    (ctrl.ld_trig),
		.addr  (addr_q),
		.cos_q (cos_q),
		.sin_q (sin_q)
	);

	// shared multiplier
	logic signed [STW-1:0] i_raw_q;
	logic signed [STW-1:0] q_raw_q;
	logic signed [STW-1:0] yi_q;
	logic signed [STW-1:0] yq_q;
	logic signed [MA-1:0]  x_ext;
	logic signed [MA-1:0]  diff_i;
	logic signed [MA-1:0]  diff_q;
	logic signed [MB-1:0]  coef_ext;
	logic signed [MA-1:0]  op_a;
	logic signed [MB-1:0]  op_b;
	logic signed [PRW-1:0] p_q;

	assign x_ext    = {{(MA - SW){x_q[SW-1]}}, x_q};
	assign diff_i   = {yi_q[STW-1], yi_q} - {i_raw_q[STW-1], i_raw_q};
	assign diff_q   = {yq_q[STW-1], yq_q} - {q_raw_q[STW-1], q_raw_q};
	assign coef_ext = {{(MB - CW){1'b0}}, coef};

	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_X_COS:   begin op_a = x_ext;  op_b = cos_q;    end
			MUL_X_SIN:   begin op_a = x_ext;  op_b = sin_q;    end
			MUL_DI_COEF: begin op_a = diff_i; op_b = coef_ext; end
			MUL_DQ_COEF: begin op_a = diff_q; op_b = coef_ext; end
			default:     begin op_a = x_ext;  op_b = cos_q;    end
		endcase
	end

	r2iq_mul #(
		.AW (MA),
		.BW (MB)
	) u_mul (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.p_q (p_q)
	);

	// rounding half away from zero: add half, less one when negative, shift
	logic signed [PRW:0]   p_ext;
	logic        [PRW:0]   p_neg;
	logic signed [PRW:0]   mix_sum;
	logic signed [PRW:0]   mix_sh;
	logic signed [PRW:0]   flt_sum;
	logic signed [PRW:0]   flt_sh;
	logic signed [STW-1:0] mix_rnd;
	logic signed [STW-1:0] raw_sel;
	logic signed [STW+1:0] y_sum;
	logic signed [STW-1:0] y_new;

	assign p_ext   = {p_q[PRW-1], p_q};
	assign p_neg   = (PRW + 1)'(p_q[PRW-1]);
	assign mix_sum = p_ext + MIX_HALF - p_neg;
	assign mix_sh  = mix_sum >>> MIX_SHIFT;
	assign mix_rnd = mix_sh[STW-1:0];
	assign flt_sum = p_ext + FLT_HALF - p_neg;
	assign flt_sh  = flt_sum >>> CW;
	assign raw_sel = ctrl.ld_yi ? i_raw_q : q_raw_q;
	assign y_sum   = {{2{raw_sel[STW-1]}}, raw_sel} + flt_sh[STW+1:0];

	always_comb begin
		if (y_sum[STW+1:STW-1] == 3'b000 || y_sum[STW+1:STW-1] == 3'b111)
			y_new = y_sum[STW-1:0];
		else
			y_new = y_sum[STW+1] ? ST_MIN : ST_MAX;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_iraw)
			i_raw_q <= mix_rnd;
		if (ctrl.ld_qraw)
			q_raw_q <= -mix_rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yi_q <= '0;
			yq_q <= '0;
		end else begin
			if (ctrl.ld_yi)
				yi_q <= y_new;
			if (ctrl.ld_yq)
				yq_q <= y_new;
		end
	end

	// filter state to sample format
	function automatic logic signed [SW-1:0] to_sample(input logic signed [STW-1:0] y);
		logic signed [STW:0] ye;
		logic signed [STW:0] s;
		logic signed [STW:0] sh;
		logic signed [SW+1:0] v;
		ye = {y[STW-1], y};
		s  = ye + OUT_HALF - (STW + 1)'(y[STW-1]);
		sh = s >>> GUARD;
		v  = sh[SW+1:0];
		if (v[SW+1:SW-1] == 3'b000 || v[SW+1:SW-1] == 3'b111)
			return v[SW-1:0];
		return v[SW+1] ? SMP_MIN : SMP_MAX;
	endfunction

	logic signed [SW-1:0] i_q;
	logic signed [SW-1:0] q_q;

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			if (byp_q) begin
				i_q <= x_q;
				q_q <= '0;
			end else begin
				i_q <= to_sample(yi_q);
				q_q <= to_sample(yq_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDW'({q_q, i_q});

	a_out_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ld_out |-> (!out_valid_q || m_axis_tready))
		else $error("result register loaded while holding an untaken item");

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> acc_q == $past(acc_next))
		else $error("phase accumulator did not advance by one step");

	a_bypass_q_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.ld_out && byp_q) |=> (m_axis_tvalid && q_q == '0))
		else $error("bypassed item left with nonzero quadrature");

endmodule

### sim/tb_real_to_iq_downconverter_lpf.sv
`timescale 1ns / 1ps

module tb_real_to_iq_downconverter_lpf;
	import r2iq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_SET = 150;

	// Expected I/Q results, kept in step with every accepted sample
	class iq_scoreboard;
		bit        enable;
		bit [31:0] step;
		bit [31:0] start;
		bit [15:0] coef;
		bit [31:0] phase_acc;
		longint    yi, yq;
		longint    cos_lut [1024];
		bit [31:0] iq_expected [$];
		int        errors;
		int        samples_seen;
		int        results_seen;

		function new();
			longint unsigned theta;
			int              k;
			for (k = 0; k < 1024; k++) begin
				theta = ((k % 256) * HALF_PI_Q30 + 128) >> 8;
				case (k / 256)
					0: cos_lut[k] = longint'(taylor(theta, 1'b0));
					1: cos_lut[k] = -longint'(taylor(theta, 1'b1));
					2: cos_lut[k] = -longint'(taylor(theta, 1'b0));
					default: cos_lut[k] = longint'(taylor(theta, 1'b1));
				endcase
			end
		endfunction

		// Q30 series: cosine when odd is clear, sine when set
		function longint unsigned taylor(longint unsigned x, bit odd);
			longint unsigned x2, term, d;
			longint          sum;
			int              n;
			x2 = (x * x + (64'd1 << 29)) >> TRIG_FRAC;
			term = odd ? x : (64'd1 << TRIG_FRAC);
			sum = longint'(term);
			for (n = 1; n <= 10; n++) begin
				d = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
				term = (((term * x2 + (64'd1 << 29)) >> TRIG_FRAC) + d / 2) / d;
				if (n % 2 == 1)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > (64'sd1 <<< TRIG_FRAC))
				sum = 64'sd1 <<< TRIG_FRAC;
			return unsigned'(sum);
		endfunction

		// round half away from zero
		function longint rshift_round(longint v, int s);
			longint half;
			half = 64'sd1 <<< (s - 1);
			if (v >= 0)
				return (v + half) >>> s;
			return -((-v + half) >>> s);
		endfunction

		function longint clip(longint v, int w);
			longint hi;
			hi = (64'sd1 <<< (w - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				CFG_CONVERT_ENABLE:     enable = v[0];
				CFG_PHASE_STEP:         step = v;
				CFG_START_PHASE:        start = v;
				CFG_FILTER_COEFFICIENT: coef = v[15:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [15:0] sample);
			longint    x, c, s, i_raw, q_raw, a, i_val, q_val;
			bit [31:0] phase;
			bit [9:0]  addr;
			bit [9:0]  sin_addr;
			x = longint'($signed(sample));
			phase = start + phase_acc;
			addr = phase[31:22];
			sin_addr = addr - 10'd256;
			phase_acc = phase_acc + step;
			if (enable) begin
				c = cos_lut[addr];
				s = cos_lut[sin_addr];
				i_raw = rshift_round(x * c, 15);
				q_raw = rshift_round(-(x * s), 15);
				a = longint'(coef);
				yi = clip(i_raw + rshift_round(a * (yi - i_raw), 16), 32);
				yq = clip(q_raw + rshift_round(a * (yq - q_raw), 16), 32);
				i_val = clip(rshift_round(yi, 15), 16);
				q_val = clip(rshift_round(yq, 15), 16);
			end else begin
				i_val = x;
				q_val = 0;
			end
			iq_expected.push_back({q_val[15:0], i_val[15:0]});
			samples_seen++;
		endfunction

		function void check_result(logic [31:0] d);
			bit [31:0] exp_iq;
			if (iq_expected.size() == 0) begin
				$display("%0t: unexpected result i_out %0d q_out %0d", $time,
					$signed(d[15:0]), $signed(d[31:16]));
				errors++;
				return;
			end
			exp_iq = iq_expected.pop_front();
			results_seen++;
			if (d[15:0] !== exp_iq[15:0]) begin
				$display("%0t: i_out expected %0d actual %0d", $time,
					$signed(exp_iq[15:0]), $signed(d[15:0]));
				errors++;
			end
			if (d[31:16] !== exp_iq[31:16]) begin
				$display("%0t: q_out expected %0d actual %0d", $time,
					$signed(exp_iq[31:16]), $signed(d[31:16]));
				errors++;
			end
		endfunction

		function int pending();
			return iq_expected.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_data;

	iq_scoreboard sb;
	int           src_idle;
	int           dst_idle;
	int           cycles;

	real_to_iq_downconverter_lpf DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side: take and check, stall at random
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= dst_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] x);
		if ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(x);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// block must be idle: every sample so far has produced its result
	task automatic program_regs(bit en, logic [31:0] step, logic [31:0] start,
			logic [15:0] coef);
		drain_results();
		write_reg(CFG_CONVERT_ENABLE, {31'd0, en});
		write_reg(CFG_PHASE_STEP, step);
		write_reg(CFG_START_PHASE, start);
		write_reg(CFG_FILTER_COEFFICIENT, {16'd0, coef});
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(4095);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int        mode, set, n;
		logic [15:0] coef;
		sb = new();
		src_idle = 0;
		dst_idle = 0;
		cycles = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr <= CFG_CONVERT_ENABLE;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bypass after reset: sample out as I, Q zero
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);

		// cos = 1, no smoothing
		program_regs(1'b1, 32'd0, 32'd0, 16'd0);
		send_sample(16'h8000);
		send_sample(16'h7FFF);

		// sin = 1: Q = -x saturates for the most negative sample
		program_regs(1'b1, 32'd0, 32'h4000_0000, 16'd0);
		send_sample(16'h8000);
		send_sample(16'h7FFF);

		// heaviest smoothing, largest step and offset
		program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		repeat (4) send_sample(16'h8000);
		repeat (2) send_sample(16'h7FFF);

		// half-turn step: carrier at Nyquist
		program_regs(1'b1, 32'h8000_0000, 32'd0, 16'h8000);
		send_sample(16'd12345);
		send_sample(-16'sd12345);
		send_sample(16'd12345);
		send_sample(-16'sd12345);

		// bypass in the middle holds the filter state, phase keeps moving
		program_regs(1'b0, 32'h8000_0000, 32'd0, 16'h8000);
		send_sample(16'd100);
		send_sample(-16'sd100);
		program_regs(1'b1, 32'h8000_0000, 32'd0, 16'h8000);
		send_sample(16'd0);

		for (mode = 0; mode < 3; mode++) begin
			drain_results();
			case (mode)
				0: begin src_idle = 37; dst_idle = 63; end
				1: begin src_idle = 63; dst_idle = 37; end
				default: begin src_idle = 0; dst_idle = 0; end
			endcase
			for (set = 0; set < 3; set++) begin
				case ($urandom_range(3))
					0: coef = 16'd0;
					1: coef = 16'hFFFF;
					2: coef = 16'hF000 | 16'($urandom_range(4095));
					default: coef = 16'($urandom);
				endcase
				program_regs($urandom_range(5) != 0, pick_word(), pick_word(), coef);
				for (n = 0; n < RAND_PER_SET; n++)
					send_sample(pick_sample());
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("Checked %0d I/Q results from %0d samples across bypass, mixing,",
			sb.results_seen, sb.samples_seen);
		$display("smoothing and saturation under three idle patterns; %0d mismatches",
			sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
